FILE: hdl/ttst_pkg.sv
// ----------------------------------------------------------------------------
// ttst_pkg
// Shared codes, types and helpers of the timer slot table.
// ----------------------------------------------------------------------------
package ttst_pkg;

    // default number of timer slots
    localparam int SLOT_COUNT_DEFAULT = 16;

    // milliseconds per second for the seconds unit
    localparam logic [31:0] MS_PER_SECOND = 32'd1000;

    // operation codes
    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_KILL     = 3'd1;
    localparam logic [2:0] OP_KILL_ALL = 3'd2;
    localparam logic [2:0] OP_RST_TIME = 3'd3;
    localparam logic [2:0] OP_SET_IVAL = 3'd4;
    localparam logic [2:0] OP_RUN      = 3'd5;

    // result status codes
    localparam logic [2:0] STATUS_DONE    = 3'd0;
    localparam logic [2:0] STATUS_FULL    = 3'd1;
    localparam logic [2:0] STATUS_IGNORED = 3'd2;
    localparam logic [2:0] STATUS_FIRED   = 3'd3;
    localparam logic [2:0] STATUS_IDLE    = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD,
        S_KILL_ALL,
        S_RST_WR,
        S_RUN,
        S_RUN_END
    } state_t;

    // update command for the slot flag bank
    typedef struct packed {
        logic set;
        logic clr;
        logic lock;
        logic one_shot;
    } flag_cmd_t;

    // scale a value given in seconds to milliseconds when secs is set, 32-bit wrap
    function automatic logic [31:0] scale_ms(input logic secs, input logic [31:0] v);
        logic [31:0] scaled;
        scaled = v * MS_PER_SECOND;
        return secs ? scaled : v;
    endfunction

endpackage

FILE: hdl/ttst_ram.sv
// ----------------------------------------------------------------------------
// ttst_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ttst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ttst_flags.sv
// ----------------------------------------------------------------------------
// ttst_flags
// Per-slot active, locked and one-shot marks, cleared at reset.
// ----------------------------------------------------------------------------
module ttst_flags #(
    parameter int SLOT_COUNT = ttst_pkg::SLOT_COUNT_DEFAULT,
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ttst_pkg::flag_cmd_t    cmd,
    input  logic [IW-1:0]          idx,
    output logic [SLOT_COUNT-1:0]  active,
    output logic [SLOT_COUNT-1:0]  locked,
    output logic [SLOT_COUNT-1:0]  one_shot
);

    logic [SLOT_COUNT-1:0] active_reg;
    logic [SLOT_COUNT-1:0] active_next;
    logic [SLOT_COUNT-1:0] locked_reg;
    logic [SLOT_COUNT-1:0] locked_next;
    logic [SLOT_COUNT-1:0] one_shot_reg;
    logic [SLOT_COUNT-1:0] one_shot_next;

    // set marks on allocation, drop active on free
    always_comb
    begin
        active_next   = active_reg;
        locked_next   = locked_reg;
        one_shot_next = one_shot_reg;
        if (cmd.set)
        begin
            active_next[idx]   = 1'b1;
            locked_next[idx]   = cmd.lock;
            one_shot_next[idx] = cmd.one_shot;
        end
        else if (cmd.clr)
        begin
            active_next[idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            locked_reg   <= '0;
            one_shot_reg <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            locked_reg   <= locked_next;
            one_shot_reg <= one_shot_next;
        end
    end

    assign active   = active_reg;
    assign locked   = locked_reg;
    assign one_shot = one_shot_reg;

endmodule

FILE: hdl/task_timer_slot_table.sv
// ----------------------------------------------------------------------------
// task_timer_slot_table
// Timer slot table: add, kill, re-arm and run scheduled tasks.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low; op,
//   now, task_id, interval, start_delay, unit_seconds and lock_flag are
//   sampled then. Results come out on status, slot_id, active_count,
//   peak_count, created_total and last, each valid for one cycle while
//   strobe is high; last marks the final result of a command. The receiver
//   cannot stall the block, every result must be taken as it appears.
//   Periods and due times live in two RAMs with registered read; the
//   slot marks are flip-flops. Add scans for the first free slot, one slot
//   per cycle; kill unlocked visits every slot, one slot per cycle; run is
//   a pipelined RAM scan, one slot per cycle, with one result in flight.
//   busy drops in the cycle of the last result, so the next command can be
//   taken then. Reset clears all slot marks and counters; no clearing pass.
// ----------------------------------------------------------------------------
module task_timer_slot_table #(
    parameter int SLOT_COUNT = ttst_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [31:0] now,
    input  logic [7:0]  task_id,
    input  logic [31:0] interval,
    input  logic [31:0] start_delay,
    input  logic        unit_seconds,
    input  logic        lock_flag,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [3:0]  slot_id,
    output logic [4:0]  active_count,
    output logic [4:0]  peak_count,
    output logic [31:0] created_total,
    output logic        last
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
    localparam logic [IW:0]   SLOTS    = (IW + 1)'(SLOT_COUNT);

    // state and command registers
    ttst_pkg::state_t state_reg, state_next;
    logic [2:0]    op_reg;
    logic [31:0]   now_reg;
    logic [7:0]    id_reg;
    logic [31:0]   ival_reg;
    logic [31:0]   delay_reg;
    logic          os_reg;
    logic          lock_reg;

    // scan and run pipeline registers
    logic [IW:0]   scan_reg, scan_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [IW-1:0] pend_slot_reg, pend_slot_next;
    logic [CW-1:0] pend_count_reg, pend_count_next;

    // counters
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] peak_reg, peak_next;
    logic [31:0]   created_reg, created_next;

    // result registers
    logic          strobe_reg;
    logic [2:0]    status_reg;
    logic [IW-1:0] slot_reg;
    logic [CW-1:0] active_reg;
    logic [CW-1:0] peak_out_reg;
    logic [31:0]   created_out_reg;
    logic          last_reg;

    // result emitted this cycle
    logic          emit;
    logic [2:0]    emit_status;
    logic [IW-1:0] emit_slot;
    logic [CW-1:0] emit_count;
    logic          emit_last;

    // slot marks
    ttst_pkg::flag_cmd_t   flag_cmd;
    logic [IW-1:0]         flag_idx;
    logic [SLOT_COUNT-1:0] active_vec;
    logic [SLOT_COUNT-1:0] locked_vec;
    logic [SLOT_COUNT-1:0] one_shot_vec;

    // ram ports
    logic          period_we;
    logic [IW-1:0] period_waddr;
    logic [31:0]   period_wdata;
    logic [31:0]   period_rdata;
    logic          due_we;
    logic [IW-1:0] due_waddr;
    logic [31:0]   due_wdata;
    logic [31:0]   due_rdata;
    logic [IW-1:0] rd_addr;

    // decoded helpers
    logic          accept;
    logic [IW-1:0] scan_idx;
    logic [IW-1:0] id_idx;
    logic          id_ok;
    logic          issue;
    logic [31:0]   diff;
    logic          fire;

    assign accept   = start && (state_reg == ttst_pkg::S_IDLE);
    assign scan_idx = scan_reg[IW-1:0];
    assign id_idx   = id_reg[IW-1:0];
    assign id_ok    = (id_reg < 8'(SLOT_COUNT)) && active_vec[id_idx];
    assign issue    = (scan_reg < SLOTS);
    assign diff     = now_reg - due_rdata;
    assign fire     = chk_vld_reg && active_vec[chk_idx_reg] && !diff[31];
    assign rd_addr  = (state_reg == ttst_pkg::S_RUN) ? scan_idx : id_idx;

    ttst_flags #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_flags (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (flag_cmd),
        .idx      (flag_idx),
        .active   (active_vec),
        .locked   (locked_vec),
        .one_shot (one_shot_vec)
    );

    ttst_ram #(
        .WIDTH (32),
        .DEPTH (SLOT_COUNT)
    ) u_period_ram (
        .clk   (clk),
        .we    (period_we),
        .waddr (period_waddr),
        .wdata (period_wdata),
        .raddr (rd_addr),
        .rdata (period_rdata)
    );

    ttst_ram #(
        .WIDTH (32),
        .DEPTH (SLOT_COUNT)
    ) u_due_ram (
        .clk   (clk),
        .we    (due_we),
        .waddr (due_waddr),
        .wdata (due_wdata),
        .raddr (rd_addr),
        .rdata (due_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttst_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ttst_pkg::S_EXEC;
                end
            end
            ttst_pkg::S_EXEC:
            begin
                case (op_reg)
                    ttst_pkg::OP_ADD:      state_next = ttst_pkg::S_ADD;
                    ttst_pkg::OP_KILL_ALL: state_next = ttst_pkg::S_KILL_ALL;
                    ttst_pkg::OP_RST_TIME:
                    begin
                        state_next = id_ok ? ttst_pkg::S_RST_WR : ttst_pkg::S_IDLE;
                    end
                    ttst_pkg::OP_RUN:      state_next = ttst_pkg::S_RUN;
                    default:               state_next = ttst_pkg::S_IDLE;
                endcase
            end
            ttst_pkg::S_ADD:
            begin
                if (!active_vec[scan_idx] || (scan_idx == LAST_IDX))
                begin
                    state_next = ttst_pkg::S_IDLE;
                end
            end
            ttst_pkg::S_KILL_ALL:
            begin
                if (scan_idx == LAST_IDX)
                begin
                    state_next = ttst_pkg::S_IDLE;
                end
            end
            ttst_pkg::S_RST_WR:
            begin
                state_next = ttst_pkg::S_IDLE;
            end
            ttst_pkg::S_RUN:
            begin
                if (chk_vld_reg && (chk_idx_reg == LAST_IDX))
                begin
                    state_next = ttst_pkg::S_RUN_END;
                end
            end
            ttst_pkg::S_RUN_END:
            begin
                state_next = ttst_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ttst_pkg::S_IDLE;
            end
        endcase
    end

    // datapath control and results
    always_comb
    begin
        scan_next       = scan_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        pend_vld_next   = pend_vld_reg;
        pend_slot_next  = pend_slot_reg;
        pend_count_next = pend_count_reg;
        count_next      = count_reg;
        peak_next       = peak_reg;
        created_next    = created_reg;
        flag_cmd        = '0;
        flag_idx        = scan_idx;
        period_we       = 1'b0;
        period_waddr    = scan_idx;
        period_wdata    = ival_reg;
        due_we          = 1'b0;
        due_waddr       = scan_idx;
        due_wdata       = now_reg + delay_reg;
        emit            = 1'b0;
        emit_status     = ttst_pkg::STATUS_DONE;
        emit_slot       = '0;
        emit_count      = count_reg;
        emit_last       = 1'b1;

        case (state_reg)
            ttst_pkg::S_EXEC:
            begin
                scan_next     = '0;
                pend_vld_next = 1'b0;
                case (op_reg)
                    ttst_pkg::OP_ADD,
                    ttst_pkg::OP_KILL_ALL,
                    ttst_pkg::OP_RUN:
                    begin
                    end
                    ttst_pkg::OP_KILL:
                    begin
                        emit = 1'b1;
                        if (id_ok)
                        begin
                            flag_cmd.clr = 1'b1;
                            flag_idx     = id_idx;
                            count_next   = count_reg - 1'b1;
                            emit_count   = count_next;
                        end
                        else
                        begin
                            emit_status = ttst_pkg::STATUS_IGNORED;
                        end
                    end
                    ttst_pkg::OP_RST_TIME:
                    begin
                        // period read issued now, due written next cycle
                        if (!id_ok)
                        begin
                            emit        = 1'b1;
                            emit_status = ttst_pkg::STATUS_IGNORED;
                        end
                    end
                    ttst_pkg::OP_SET_IVAL:
                    begin
                        emit = 1'b1;
                        if (id_ok)
                        begin
                            period_we    = 1'b1;
                            period_waddr = id_idx;
                        end
                        else
                        begin
                            emit_status = ttst_pkg::STATUS_IGNORED;
                        end
                    end
                    default:
                    begin
                        emit        = 1'b1;
                        emit_status = ttst_pkg::STATUS_IGNORED;
                    end
                endcase
            end
            ttst_pkg::S_ADD:
            begin
                // first free slot in order
                if (!active_vec[scan_idx])
                begin
                    flag_cmd.set      = 1'b1;
                    flag_cmd.lock     = lock_reg;
                    flag_cmd.one_shot = os_reg;
                    period_we         = 1'b1;
                    due_we            = 1'b1;
                    count_next        = count_reg + 1'b1;
                    created_next      = created_reg + 32'd1;
                    peak_next         = (count_next > peak_reg) ? count_next : peak_reg;
                    emit              = 1'b1;
                    emit_slot         = scan_idx;
                    emit_count        = count_next;
                end
                else if (scan_idx == LAST_IDX)
                begin
                    emit        = 1'b1;
                    emit_status = ttst_pkg::STATUS_FULL;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ttst_pkg::S_KILL_ALL:
            begin
                if (active_vec[scan_idx] && !locked_vec[scan_idx])
                begin
                    flag_cmd.clr = 1'b1;
                    count_next   = count_reg - 1'b1;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_idx == LAST_IDX)
                begin
                    emit       = 1'b1;
                    emit_count = count_next;
                end
            end
            ttst_pkg::S_RST_WR:
            begin
                due_we     = 1'b1;
                due_waddr  = id_idx;
                due_wdata  = now_reg + period_rdata;
                emit       = 1'b1;
            end
            ttst_pkg::S_RUN:
            begin
                // issue the read of the next slot, check the one read last cycle
                if (issue)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                chk_vld_next = issue;
                chk_idx_next = scan_idx;
                if (fire)
                begin
                    if (one_shot_vec[chk_idx_reg])
                    begin
                        flag_cmd.clr = 1'b1;
                        flag_idx     = chk_idx_reg;
                        count_next   = count_reg - 1'b1;
                    end
                    else
                    begin
                        due_we    = 1'b1;
                        due_waddr = chk_idx_reg;
                        due_wdata = now_reg + period_rdata;
                    end
                    // hand out the previous firing, hold this one back
                    emit            = pend_vld_reg;
                    emit_status     = ttst_pkg::STATUS_FIRED;
                    emit_slot       = pend_slot_reg;
                    emit_count      = pend_count_reg;
                    emit_last       = 1'b0;
                    pend_vld_next   = 1'b1;
                    pend_slot_next  = chk_idx_reg;
                    pend_count_next = count_next;
                end
            end
            ttst_pkg::S_RUN_END:
            begin
                emit = 1'b1;
                if (pend_vld_reg)
                begin
                    emit_status = ttst_pkg::STATUS_FIRED;
                    emit_slot   = pend_slot_reg;
                    emit_count  = pend_count_reg;
                end
                else
                begin
                    emit_status = ttst_pkg::STATUS_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ttst_pkg::S_IDLE;
            scan_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            count_reg    <= '0;
            peak_reg     <= '0;
            created_reg  <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            chk_vld_reg  <= chk_vld_next;
            pend_vld_reg <= pend_vld_next;
            count_reg    <= count_next;
            peak_reg     <= peak_next;
            created_reg  <= created_next;
            strobe_reg   <= emit;
        end
    end

    // command capture and payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            now_reg   <= now;
            id_reg    <= task_id;
            ival_reg  <= ttst_pkg::scale_ms(unit_seconds, interval);
            delay_reg <= ttst_pkg::scale_ms(unit_seconds, start_delay);
            os_reg    <= (interval == 32'd0);
            lock_reg  <= lock_flag;
        end
        chk_idx_reg    <= chk_idx_next;
        pend_slot_reg  <= pend_slot_next;
        pend_count_reg <= pend_count_next;
        if (emit)
        begin
            status_reg      <= emit_status;
            slot_reg        <= emit_slot;
            active_reg      <= emit_count;
            peak_out_reg    <= peak_next;
            created_out_reg <= created_next;
            last_reg        <= emit_last;
        end
    end

    assign busy          = (state_reg != ttst_pkg::S_IDLE);
    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign slot_id       = 4'(slot_reg);
    assign active_count  = 5'(active_reg);
    assign peak_count    = 5'(peak_out_reg);
    assign created_total = created_out_reg;
    assign last          = last_reg;

    // the final result of a command always leaves the sequencer idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |-> state_reg == ttst_pkg::S_IDLE)
        else $error("final result while sequencer still busy");

    // only a run produces results that are not final
    a_multi_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |->
            (state_reg == ttst_pkg::S_RUN) || (state_reg == ttst_pkg::S_RUN_END))
        else $error("non-final result outside run");

    // active count stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOT_COUNT))
        else $error("active count beyond slot count");

    // peak never trails the active count
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= count_reg)
        else $error("peak count below active count");

    // an accepted command enters execution next cycle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ttst_pkg::S_EXEC)
        else $error("accepted command not executed");

endmodule

FILE: tb/tb_task_timer_slot_table.sv
// ----------------------------------------------------------------------------
// tb_task_timer_slot_table
// Self-checking bench for the timer slot table.
// A short directed table hits the ignored ids, the unused op codes, the
// seconds scaling with wrap, a period that scales to zero, a full table and
// a run that fires every slot. Random commands follow on a mostly rising
// millisecond clock. Every result is checked field by field against an
// in-bench prediction of the slot table.
// ----------------------------------------------------------------------------
module tb_task_timer_slot_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = ttst_pkg::SLOT_COUNT_DEFAULT;
    localparam int RANDOM_CMDS = 130;
    localparam int QUIET_TAIL  = 30;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTS  = 40;

    // op codes the block does not define
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    // one command transaction, plus a repeat count and an optional typed answer
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] now;
        logic [7:0]  id;
        logic [31:0] ival;
        logic [31:0] delay;
        logic        secs;
        logic        lock;
        logic [4:0]  reps;
        logic        typed;
        logic [2:0]  want_status;
        logic [3:0]  want_slot;
    } timer_cmd_t;

    // one result transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [4:0]  active;
        logic [4:0]  peak;
        logic [31:0] created;
        logic        last;
    } timer_report_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [31:0] now;
    logic [7:0]  task_id;
    logic [31:0] interval;
    logic [31:0] start_delay;
    logic        unit_seconds;
    logic        lock_flag;
    logic        strobe;
    logic [2:0]  status;
    logic [3:0]  slot_id;
    logic [4:0]  active_count;
    logic [4:0]  peak_count;
    logic [31:0] created_total;
    logic        last;

    // predicted slot table
    logic [15:0] tbl_active;
    logic [15:0] tbl_locked;
    logic [15:0] tbl_one_shot;
    logic [31:0] tbl_period [SLOTS];
    logic [31:0] tbl_due [SLOTS];
    logic [4:0]  tbl_count;
    logic [4:0]  tbl_peak;
    logic [31:0] tbl_created;

    timer_report_t timer_reports_owed[$];
    timer_report_t oldest_owed;
    timer_cmd_t    directed_cmds[$];

    int          mismatch_count;
    int          results_checked;
    int          cmds_sent;
    int          firings_seen;
    int          cycle_count;
    logic [31:0] clock_ms;

    task_timer_slot_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .now           (now),
        .task_id       (task_id),
        .interval      (interval),
        .start_delay   (start_delay),
        .unit_seconds  (unit_seconds),
        .lock_flag     (lock_flag),
        .strobe        (strobe),
        .status        (status),
        .slot_id       (slot_id),
        .active_count  (active_count),
        .peak_count    (peak_count),
        .created_total (created_total),
        .last          (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, timer_reports_owed.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch %s at cycle %0d: got %0h, want %0h",
                     what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // queue one predicted result with the current counters
    task automatic log_report(input logic [2:0] st, input logic [3:0] slot);
        timer_report_t r;
        r.status  = st;
        r.slot    = slot;
        r.active  = tbl_count;
        r.peak    = tbl_peak;
        r.created = tbl_created;
        r.last    = 1'b0;
        timer_reports_owed.push_back(r);
    endtask

    task automatic release_slot(input int i);
        tbl_active[i] = 1'b0;
        if (tbl_count > 0)
            tbl_count = tbl_count - 5'd1;
    endtask

    // predict the results of one accepted command and update the table
    task automatic apply_timer_command(input timer_cmd_t c);
        int            i;
        int            free_idx;
        int            fired;
        logic [31:0]   ival_ms;
        logic [31:0]   delay_ms;
        logic [31:0]   lag;
        logic          id_live;
        timer_report_t tail;
        ival_ms  = c.secs ? c.ival * ttst_pkg::MS_PER_SECOND : c.ival;
        delay_ms = c.secs ? c.delay * ttst_pkg::MS_PER_SECOND : c.delay;
        id_live  = (c.id < SLOTS) && tbl_active[c.id[3:0]];
        fired    = 0;
        case (c.op)
            ttst_pkg::OP_ADD:
            begin
                // lowest free slot wins
                free_idx = -1;
                for (i = SLOTS - 1; i >= 0; i--)
                    if (!tbl_active[i])
                        free_idx = i;
                if (free_idx < 0)
                    log_report(ttst_pkg::STATUS_FULL, 4'd0);
                else
                begin
                    tbl_active[free_idx]   = 1'b1;
                    tbl_locked[free_idx]   = c.lock;
                    tbl_one_shot[free_idx] = (c.ival == 32'd0);
                    tbl_period[free_idx]   = ival_ms;
                    tbl_due[free_idx]      = c.now + delay_ms;
                    tbl_count              = tbl_count + 5'd1;
                    tbl_created            = tbl_created + 32'd1;
                    if (tbl_count > tbl_peak)
                        tbl_peak = tbl_count;
                    log_report(ttst_pkg::STATUS_DONE, free_idx[3:0]);
                end
            end
            ttst_pkg::OP_KILL:
            begin
                if (id_live)
                begin
                    release_slot(int'(c.id[3:0]));
                    log_report(ttst_pkg::STATUS_DONE, 4'd0);
                end
                else
                    log_report(ttst_pkg::STATUS_IGNORED, 4'd0);
            end
            ttst_pkg::OP_KILL_ALL:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (tbl_active[i] && !tbl_locked[i])
                        release_slot(i);
                log_report(ttst_pkg::STATUS_DONE, 4'd0);
            end
            ttst_pkg::OP_RST_TIME:
            begin
                if (id_live)
                begin
                    tbl_due[c.id[3:0]] = c.now + tbl_period[c.id[3:0]];
                    log_report(ttst_pkg::STATUS_DONE, 4'd0);
                end
                else
                    log_report(ttst_pkg::STATUS_IGNORED, 4'd0);
            end
            ttst_pkg::OP_SET_IVAL:
            begin
                // the one-shot mark stays as set by add
                if (id_live)
                begin
                    tbl_period[c.id[3:0]] = ival_ms;
                    log_report(ttst_pkg::STATUS_DONE, 4'd0);
                end
                else
                    log_report(ttst_pkg::STATUS_IGNORED, 4'd0);
            end
            ttst_pkg::OP_RUN:
            begin
                // wrap-safe due test: sign of now minus due
                for (i = 0; i < SLOTS; i++)
                begin
                    if (tbl_active[i])
                    begin
                        lag = c.now - tbl_due[i];
                        if (!lag[31])
                        begin
                            if (tbl_one_shot[i])
                                release_slot(i);
                            else
                                tbl_due[i] = c.now + tbl_period[i];
                            log_report(ttst_pkg::STATUS_FIRED, i[3:0]);
                            fired++;
                        end
                    end
                end
                if (fired == 0)
                    log_report(ttst_pkg::STATUS_IDLE, 4'd0);
                firings_seen += fired;
            end
            default:
                log_report(ttst_pkg::STATUS_IGNORED, 4'd0);
        endcase
        // mark the final result, and take a typed answer where one is given
        tail      = timer_reports_owed.pop_back();
        tail.last = 1'b1;
        if (c.typed)
        begin
            tail.status = c.want_status;
            tail.slot   = c.want_slot;
        end
        timer_reports_owed.push_back(tail);
    endtask

    // drive one command at a falling edge and hold it until accepted
    task automatic send_cmd(input timer_cmd_t c);
        op           = c.op;
        now          = c.now;
        task_id      = c.id;
        interval     = c.ival;
        start_delay  = c.delay;
        unit_seconds = c.secs;
        lock_flag    = c.lock;
        start        = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_timer_command(c);
        cmds_sent++;
        @(negedge clk);
    endtask

    task automatic hold_off(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic timer_cmd_t mk_cmd(
        input logic [2:0] c_op, input logic [31:0] c_now, input logic [7:0] c_id,
        input logic [31:0] c_ival, input logic [31:0] c_delay, input logic c_secs,
        input logic c_lock, input logic [4:0] c_reps, input logic c_typed,
        input logic [2:0] c_status, input logic [3:0] c_slot);
        timer_cmd_t c;
        c.op          = c_op;
        c.now         = c_now;
        c.id          = c_id;
        c.ival        = c_ival;
        c.delay       = c_delay;
        c.secs        = c_secs;
        c.lock        = c_lock;
        c.reps        = c_reps;
        c.typed       = c_typed;
        c.want_status = c_status;
        c.want_slot   = c_slot;
        return c;
    endfunction

    // random interval or delay: mostly short, sometimes zero or any 32-bit value
    function automatic logic [31:0] roll_span(input logic secs);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'd0;
        else if (pick == 1)
            return $urandom;
        else if (secs)
            return $urandom_range(0, 3);
        else
            return $urandom_range(1, 2500);
    endfunction

    // build one random command on the running millisecond clock
    task automatic roll_random_cmd(output timer_cmd_t c);
        int pick;
        int tries;
        c = '0;
        pick = $urandom_range(0, 39);
        if (pick == 0)
            clock_ms = $urandom;
        else if (pick == 1)
            clock_ms = clock_ms + 32'h8000_0000 - $urandom_range(0, 2);
        else
            clock_ms = clock_ms + $urandom_range(0, 1200);
        c.now   = clock_ms;
        c.secs  = ($urandom_range(0, 5) == 0);
        c.ival  = roll_span(c.secs);
        c.delay = roll_span(c.secs);
        c.lock  = ($urandom_range(0, 3) == 0);
        c.reps  = 5'd1;
        // ids: mostly a live slot, sometimes any slot, sometimes any byte
        pick = $urandom_range(0, 9);
        if (pick == 0)
            c.id = 8'($urandom_range(0, 255));
        else
        begin
            tries = 0;
            c.id  = 8'($urandom_range(0, SLOTS - 1));
            while (!tbl_active[c.id[3:0]] && tries < 8 && pick > 1)
            begin
                c.id = 8'($urandom_range(0, SLOTS - 1));
                tries++;
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 28)
            c.op = ttst_pkg::OP_ADD;
        else if (pick < 58)
            c.op = ttst_pkg::OP_RUN;
        else if (pick < 66)
            c.op = ttst_pkg::OP_KILL;
        else if (pick < 71)
            c.op = ttst_pkg::OP_KILL_ALL;
        else if (pick < 83)
            c.op = ttst_pkg::OP_RST_TIME;
        else if (pick < 96)
            c.op = ttst_pkg::OP_SET_IVAL;
        else if (pick < 98)
            c.op = OP_UNUSED_6;
        else
            c.op = OP_UNUSED_7;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (timer_reports_owed.size() == 0)
                report_mismatch("result with nothing owed, status", 32'(status), 32'd0);
            else
            begin
                oldest_owed = timer_reports_owed.pop_front();
                results_checked++;
                if (status !== oldest_owed.status)
                    report_mismatch("status", 32'(status), 32'(oldest_owed.status));
                if (slot_id !== oldest_owed.slot)
                    report_mismatch("slot_id", 32'(slot_id), 32'(oldest_owed.slot));
                if (active_count !== oldest_owed.active)
                    report_mismatch("active_count", 32'(active_count),
                                    32'(oldest_owed.active));
                if (peak_count !== oldest_owed.peak)
                    report_mismatch("peak_count", 32'(peak_count), 32'(oldest_owed.peak));
                if (created_total !== oldest_owed.created)
                    report_mismatch("created_total", created_total, oldest_owed.created);
                if (last !== oldest_owed.last)
                    report_mismatch("last", 32'(last), 32'(oldest_owed.last));
            end
        end
    end

    // stimulus
    initial
    begin
        timer_cmd_t c;
        int         counted;
        int         r;
        int         k;
        logic       paused;

        rst_n          = 1'b0;
        start          = 1'b0;
        op             = ttst_pkg::OP_RUN;
        now            = 32'd0;
        task_id        = 8'd0;
        interval       = 32'd0;
        start_delay    = 32'd0;
        unit_seconds   = 1'b0;
        lock_flag      = 1'b0;
        tbl_active     = '0;
        tbl_locked     = '0;
        tbl_one_shot   = '0;
        tbl_count      = '0;
        tbl_peak       = '0;
        tbl_created    = '0;
        mismatch_count = 0;
        results_checked = 0;
        cmds_sent      = 0;
        firings_seen   = 0;
        cycle_count    = 0;
        clock_ms       = 32'h7FFF_F000;
        paused         = 1'b0;

        // directed table: ignored ids, unused ops, scaling, full table
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_RUN, 32'd0, 8'd0, 32'd0, 32'd0,
                                       1'b0, 1'b0, 5'd1, 1'b1, ttst_pkg::STATUS_IDLE,
                                       4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_KILL, 32'd0, 8'd0, 32'd0, 32'd0,
                                       1'b0, 1'b0, 5'd1, 1'b1, ttst_pkg::STATUS_IGNORED,
                                       4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_KILL, 32'd0, 8'd255, 32'd0, 32'd0,
                                       1'b0, 1'b0, 5'd1, 1'b1, ttst_pkg::STATUS_IGNORED,
                                       4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_RST_TIME, 32'd0, 8'd16, 32'd0, 32'd0,
                                       1'b0, 1'b0, 5'd1, 1'b1, ttst_pkg::STATUS_IGNORED,
                                       4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_SET_IVAL, 32'd0, 8'd128,
                                       32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_IGNORED, 4'd0));
        directed_cmds.push_back(mk_cmd(OP_UNUSED_6, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 1'b1, 1'b1, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_IGNORED, 4'd0));
        directed_cmds.push_back(mk_cmd(OP_UNUSED_7, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                                       5'd1, 1'b1, ttst_pkg::STATUS_IGNORED, 4'd0));
        // one-shot due at once
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_ADD, 32'd0, 8'd0, 32'd0, 32'd0,
                                       1'b0, 1'b0, 5'd1, 1'b1, ttst_pkg::STATUS_DONE,
                                       4'd0));
        // largest period and delay, locked
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_ADD, 32'd0, 8'd0, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 1'b0, 1'b1, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_DONE, 4'd1));
        // seconds period that wraps to zero ms: still periodic
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_ADD, 32'd100, 8'd0, 32'h2000_0000,
                                       32'd0, 1'b1, 1'b0, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_DONE, 4'd2));
        // seconds period and delay that wrap in the multiply
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_ADD, 32'd100, 8'd0, 32'd4294968,
                                       32'hFFFF_FFFF, 1'b1, 1'b0, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_DONE, 4'd3));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_RUN, 32'd0, 8'd0, 32'd0, 32'd0,
                                       1'b0, 1'b0, 5'd1, 1'b0, ttst_pkg::STATUS_DONE,
                                       4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_RST_TIME, 32'd5, 8'd1, 32'd0, 32'd0,
                                       1'b0, 1'b0, 5'd1, 1'b1, ttst_pkg::STATUS_DONE,
                                       4'd0));
        // zero period on a periodic slot keeps it periodic
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_SET_IVAL, 32'd5, 8'd2, 32'd0, 32'd0,
                                       1'b0, 1'b0, 5'd1, 1'b1, ttst_pkg::STATUS_DONE,
                                       4'd0));
        // time edges around the sign bit
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_RUN, 32'h7FFF_FFFF, 8'd0, 32'd0,
                                       32'd0, 1'b0, 1'b0, 5'd1, 1'b0,
                                       ttst_pkg::STATUS_DONE, 4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_RUN, 32'h8000_0000, 8'd0, 32'd0,
                                       32'd0, 1'b0, 1'b0, 5'd1, 1'b0,
                                       ttst_pkg::STATUS_DONE, 4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_KILL, 32'h8000_0000, 8'd3, 32'd0,
                                       32'd0, 1'b0, 1'b0, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_DONE, 4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_KILL_ALL, 32'h8000_0000, 8'd0, 32'd0,
                                       32'd0, 1'b0, 1'b0, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_DONE, 4'd0));
        // fill the table around the locked slot, then overflow it
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_ADD, 32'h7FFF_F000, 8'd0, 32'd0,
                                       32'd0, 1'b0, 1'b0, 5'd15, 1'b0,
                                       ttst_pkg::STATUS_DONE, 4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_ADD, 32'h7FFF_F000, 8'd0, 32'd0,
                                       32'd0, 1'b0, 1'b0, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_FULL, 4'd0));
        // every slot due at once
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_RUN, 32'h7FFF_FFFF, 8'd0, 32'd0,
                                       32'd0, 1'b0, 1'b0, 5'd1, 1'b0,
                                       ttst_pkg::STATUS_DONE, 4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_KILL_ALL, 32'h7FFF_FFFF, 8'd0, 32'd0,
                                       32'd0, 1'b0, 1'b0, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_DONE, 4'd0));
        directed_cmds.push_back(mk_cmd(ttst_pkg::OP_KILL, 32'h7FFF_FFFF, 8'd1, 32'd0,
                                       32'd0, 1'b0, 1'b0, 5'd1, 1'b1,
                                       ttst_pkg::STATUS_DONE, 4'd0));

        // reset
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, back to back
        for (r = 0; r < directed_cmds.size(); r++)
            for (k = 0; k < directed_cmds[r].reps; k++)
                send_cmd(directed_cmds[r]);

        // let the table drain before the random part
        start = 1'b0;
        while (timer_reports_owed.size() != 0)
            @(negedge clk);

        // random part
        counted = 0;
        while (counted < RANDOM_CMDS)
        begin
            roll_random_cmd(c);
            if (counted < RANDOM_CMDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 8));
            if (counted == RANDOM_CMDS / 2 && !paused)
            begin
                paused = 1'b1;
                start  = 1'b0;
                while (timer_reports_owed.size() != 0)
                    @(negedge clk);
            end
            send_cmd(c);
            if (c.op <= ttst_pkg::OP_RUN)
                counted++;
        end
        start = 1'b0;

        // drain, then watch for stray results
        while (timer_reports_owed.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        $display("covered %0d commands and %0d checked results, %0d timer firings",
                 cmds_sent, results_checked, firings_seen);
        $display("table peak %0d of %0d slots, %0d tasks created",
                 tbl_peak, SLOTS, tbl_created);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ttst_pkg.sv
hdl/ttst_ram.sv
hdl/ttst_flags.sv
hdl/task_timer_slot_table.sv
tb/tb_task_timer_slot_table.sv
